// File: design/pid_bitmap_allocator_defines.svh
// assertion macros for the pid bitmap allocator
// used by pid_bitmap_allocator.sv, the rtl file that carries concurrent checks; no other dependencies
`ifndef PID_BITMAP_ALLOCATOR_DEFINES_SVH
`define PID_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define PBA_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("pba assertion failed");
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pba assertion failed");
`else
`define PBA_ASSERT(lbl, clk, rst_n, expr)
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/pba_pkg.sv
// shared types and constants for the pid bitmap allocator
// no dependencies
`default_nettype none

package pba_pkg;

	localparam int ID_W = 15;

	localparam logic [1:0] ST_GRANTED   = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_RELEASED  = 2'd2;
	localparam logic [1:0] ST_IGNORED   = 2'd3;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [ID_W-1:0] BASE_RESET = 15'd300;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic chk;
	} pba_cmd_t;

	typedef struct packed {
		logic s1_vld;
		logic fin;
	} pba_stat_t;

endpackage

`default_nettype wire

// File: design/pid_bitmap_allocator.sv
// a new start is taken only while idle; release reads the addressed bitmap word,
// checks it and registers the result; allocate checks one word a cycle from word 0
// to the first with a free slot or word WORDS-1, WORDS = ceil(POOL_SIZE/32);
// reset: async, all slots free at once through per-word valid flags, base 300;
// results are a one-cycle done strobe that the receiver cannot stall
`default_nettype none
`include "pid_bitmap_allocator_defines.svh"

module pid_bitmap_allocator #(
	parameter int POOL_SIZE = 512
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    func,
	input  wire logic [pba_pkg::ID_W-1:0] release_id,
	input  wire logic                    cfg_we,
	input  wire logic [pba_pkg::ID_W-1:0] cfg_wdata,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [pba_pkg::ID_W-1:0]     granted_id
);
	import pba_pkg::*;

	pba_cmd_t  cmd;
	pba_stat_t stat;

	pba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pba_datapath #(
		.POOL_SIZE (POOL_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.release_id (release_id),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.stat       (stat),
		.done       (done),
		.status     (status),
		.granted_id (granted_id)
	);

	`PBA_ASSERT(a_done_idle, clk, arst_n, !done || !busy)
	`PBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`PBA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`PBA_ASSERT(a_id_zero, clk, arst_n, !done || status == ST_GRANTED || granted_id == '0)

endmodule

`default_nettype wire

// File: design/pba_ctrl.sv
// controller state machine for the pid bitmap allocator
// depends on pba_pkg for the command and status structs
`default_nettype none

module pba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pba_pkg::pba_stat_t stat,
	output pba_pkg::pba_cmd_t      cmd,
	output logic                   busy
);
	import pba_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						busy_q  <= 1'b1;
					end
				end
				S_RUN: begin
					if (stat.s1_vld && stat.fin) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.load  = (state_q == S_IDLE) && start;
	assign cmd.rd_en = (state_q == S_RUN);
	assign cmd.chk   = (state_q == S_RUN) && stat.s1_vld;
	assign busy      = busy_q;

endmodule

`default_nettype wire

// File: design/pba_datapath.sv
// datapath: bitmap word memory with per-word valid flags, first-free scan,
// release lookup and result registers; depends on pba_pkg
`default_nettype none

module pba_datapath #(
	parameter int POOL_SIZE = 512
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pba_pkg::pba_cmd_t       cmd,
	input  wire logic                    func,
	input  wire logic [pba_pkg::ID_W-1:0] release_id,
	input  wire logic                    cfg_we,
	input  wire logic [pba_pkg::ID_W-1:0] cfg_wdata,
	output pba_pkg::pba_stat_t           stat,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [pba_pkg::ID_W-1:0]     granted_id
);
	import pba_pkg::*;

	localparam int WORDS  = (POOL_SIZE + 31) / 32;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SLOT_W = AW + 5;
	localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);

	logic [31:0]     mem [WORDS];
	logic [WORDS-1:0] wvld_q;

	logic [ID_W-1:0] base_q;
	logic            func_q;
	logic [ID_W-1:0] rid_q;
	logic [AW-1:0]   cnt_q;

	logic            rd_vld_s1;
	logic [AW-1:0]   addr_s1;
	logic [31:0]     rdata_s1;
	logic            wvld_s1;

	logic            done_q;
	logic [1:0]      status_q;
	logic [ID_W-1:0] gid_q;

	logic [ID_W:0]   diff;
	logic            oor;
	logic [SLOT_W-1:0] rel_slot;
	logic [AW-1:0]   rel_word;
	logic [4:0]      rel_bit;
	logic [AW-1:0]   raddr;

	logic [31:0]     word_eff;
	logic [31:0]     free_bits;
	logic            free_any;
	logic [4:0]      free_idx;
	logic [SLOT_W-1:0] slot;
	logic [ID_W:0]   id_sum;
	logic            slot_ok;
	logic            bit_set;
	logic            fin;

	logic            we;
	logic [31:0]     wdata;
	logic [1:0]      res_status;
	logic [ID_W-1:0] res_id;

	// release lookup
	assign diff     = {1'b0, rid_q} - {1'b0, base_q};
	assign oor      = diff[ID_W] || (diff[ID_W-1:0] >= ID_W'(POOL_SIZE));
	assign rel_slot = diff[SLOT_W-1:0];
	assign rel_word = rel_slot[SLOT_W-1:5];
	assign rel_bit  = rel_slot[4:0];
	assign raddr    = (func_q == FUNC_RELEASE) ? rel_word : cnt_q;

	// first free slot of the checked word
	assign word_eff  = wvld_s1 ? rdata_s1 : 32'd0;
	assign free_bits = ~word_eff;
	assign free_any  = |free_bits;

	always_comb begin
		free_idx = 5'd0;
		for (int k = 31; k >= 0; k--) begin
			if (free_bits[k]) begin
				free_idx = 5'(k);
			end
		end
	end

	assign slot    = {addr_s1, free_idx};
	assign id_sum  = {1'b0, base_q} + (ID_W+1)'(slot);
	assign slot_ok = (ID_W'(slot) < ID_W'(POOL_SIZE)) && !id_sum[ID_W];
	assign bit_set = word_eff[rel_bit];

	assign fin = (func_q == FUNC_RELEASE) || free_any || (addr_s1 == LAST_W);

	always_comb begin
		we         = 1'b0;
		wdata      = word_eff;
		res_status = ST_IGNORED;
		res_id     = '0;
		if (func_q == FUNC_ALLOC) begin
			if (free_any && slot_ok) begin
				we         = cmd.chk;
				wdata      = word_eff | (32'd1 << free_idx);
				res_status = ST_GRANTED;
				res_id     = id_sum[ID_W-1:0];
			end else begin
				res_status = ST_EXHAUSTED;
			end
		end else begin
			if (!oor && bit_set) begin
				we         = cmd.chk;
				wdata      = word_eff & ~(32'd1 << rel_bit);
				res_status = ST_RELEASED;
			end
		end
	end

	assign stat.s1_vld = rd_vld_s1;
	assign stat.fin    = fin;

	// bitmap memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_s1] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= '0;
		end else if (we) begin
			wvld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_RESET;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.rd_en && (cnt_q != LAST_W)) begin
				cnt_q <= cnt_q + AW'(1);
			end
			rd_vld_s1 <= cmd.rd_en;
			done_q    <= cmd.chk && fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			rid_q  <= release_id;
		end
		if (cmd.rd_en) begin
			addr_s1 <= raddr;
			wvld_s1 <= wvld_q[raddr];
		end
		if (cmd.chk && fin) begin
			status_q <= res_status;
			gid_q    <= res_id;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign granted_id = gid_q;

endmodule

`default_nettype wire
